// File: rtl/core/srt_pkg.sv
package srt_pkg;

    // element width
    localparam int WORD_W = 32;

    // input beat: one element of the set
    typedef struct packed {
        logic signed [WORD_W-1:0] value;
        logic                     last;
    } in_t;

    // output beat: one sorted element
    typedef struct packed {
        logic signed [WORD_W-1:0] sorted_value;
        logic                     last_out;
        logic                     overflow;
    } out_t;

endpackage

// File: rtl/core/descending_integer_sorter.sv
// descending integer sorter
// input channel: in_valid / in_stall / in_data, one signed element per beat,
// in_data.last closes the set. up to MAX_LEN elements are kept; further
// elements of the set are dropped and every result of that set carries
// overflow.
// output channel: out_valid / out_stall / out_data, the kept elements largest
// first, out_data.last_out on the final one.
// loading accepts one element per cycle. once the set is closed the block
// sorts in place with one shared compare unit and one read and one write of
// the element memory per cycle: each pass runs S_START, S_FIRST, S_CMP for
// each adjacent pair, then S_TAIL, and at most n passes run for n elements.
// emission reads each element in S_EREAD and loads it in S_EHOLD.
// in_stall is high after the closing beat until the last result has been
// loaded into the output register; the block is not ready meanwhile.
// a stalled output beat is held in the output register until taken, and
// emission waits for it. reset empties the set and clears the output
// valid; payload and memory contents are not cleared and need no clearing.
module descending_integer_sorter
    import srt_pkg::*;
#(
    parameter int MAX_LEN = 32
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_stall,
    output out_t out_data
);

    localparam int AW    = $clog2(MAX_LEN);
    localparam int CNT_W = $clog2(MAX_LEN + 1);

    typedef enum logic [2:0] {
        S_LOAD,
        S_START,
        S_FIRST,
        S_CMP,
        S_TAIL,
        S_EREAD,
        S_EHOLD
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             dropped_reg, dropped_next;
    logic [AW-1:0]    idx_reg, idx_next;
    logic             swapped_reg, swapped_next;
    logic signed [WORD_W-1:0] carry_reg, carry_next;
    logic             out_valid_reg, out_valid_next;
    out_t             out_data_reg, out_data_next;

    // element memory
    logic signed [WORD_W-1:0] store_reg [MAX_LEN];
    logic signed [WORD_W-1:0] rd_data_reg;
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic signed [WORD_W-1:0] wr_data;
    logic [AW-1:0]            rd_addr;

    logic signed [WORD_W-1:0] cmp_larger;
    logic signed [WORD_W-1:0] cmp_smaller;
    logic                     cmp_swap;

    logic [CNT_W-1:0] cnt_after;
    logic [AW-1:0]    last_idx;

    // shared compare and select unit
    srt_cmp u_cmp (
        .incoming (rd_data_reg),
        .carried  (carry_reg),
        .larger   (cmp_larger),
        .smaller  (cmp_smaller),
        .swap     (cmp_swap)
    );

    // memory write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= store_reg[rd_addr];
    end

    assign last_idx  = AW'(cnt_reg - CNT_W'(1));
    assign in_stall  = (state_reg != S_LOAD);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // sequencer: load, bubble passes through memory, emit
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        dropped_next   = dropped_reg;
        idx_next       = idx_reg;
        swapped_next   = swapped_reg;
        carry_next     = carry_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        wr_en          = 1'b0;
        wr_addr        = idx_reg;
        wr_data        = carry_reg;
        rd_addr        = idx_reg;
        cnt_after      = cnt_reg;

        // output beat taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_LOAD:
            begin
                if (in_valid)
                begin
                    if (cnt_reg < CNT_W'(MAX_LEN))
                    begin
                        wr_en     = 1'b1;
                        wr_addr   = cnt_reg[AW-1:0];
                        wr_data   = in_data.value;
                        cnt_after = cnt_reg + CNT_W'(1);
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    cnt_next = cnt_after;
                    if (in_data.last)
                    begin
                        idx_next = '0;
                        if (cnt_after >= CNT_W'(2))
                        begin
                            state_next = S_START;
                        end
                        else
                        begin
                            state_next = S_EREAD;
                        end
                    end
                end
            end

            S_START:
            begin
                rd_addr    = '0;
                state_next = S_FIRST;
            end

            S_FIRST:
            begin
                carry_next   = rd_data_reg;
                rd_addr      = AW'(1);
                idx_next     = '0;
                swapped_next = 1'b0;
                state_next   = S_CMP;
            end

            S_CMP:
            begin
                wr_en        = 1'b1;
                wr_addr      = idx_reg;
                wr_data      = cmp_larger;
                carry_next   = cmp_smaller;
                swapped_next = swapped_reg | cmp_swap;
                if (AW'(idx_reg + AW'(1)) == last_idx)
                begin
                    state_next = S_TAIL;
                end
                else
                begin
                    idx_next = AW'(idx_reg + AW'(1));
                    rd_addr  = AW'(idx_reg + AW'(2));
                end
            end

            S_TAIL:
            begin
                wr_en   = 1'b1;
                wr_addr = last_idx;
                wr_data = carry_reg;
                if (swapped_reg)
                begin
                    state_next = S_START;
                end
                else
                begin
                    idx_next   = '0;
                    state_next = S_EREAD;
                end
            end

            S_EREAD:
            begin
                rd_addr    = idx_reg;
                state_next = S_EHOLD;
            end

            S_EHOLD:
            begin
                rd_addr = idx_reg;
                if (!out_valid_reg || !out_stall)
                begin
                    out_data_next.sorted_value = rd_data_reg;
                    out_data_next.last_out     = (idx_reg == last_idx);
                    out_data_next.overflow     = dropped_reg;
                    out_valid_next             = 1'b1;
                    if (idx_reg == last_idx)
                    begin
                        cnt_next     = '0;
                        dropped_next = 1'b0;
                        state_next   = S_LOAD;
                    end
                    else
                    begin
                        idx_next   = AW'(idx_reg + AW'(1));
                        state_next = S_EREAD;
                    end
                end
            end

            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            cnt_reg       <= '0;
            dropped_reg   <= 1'b0;
            idx_reg       <= '0;
            swapped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            dropped_reg   <= dropped_next;
            idx_reg       <= idx_next;
            swapped_reg   <= swapped_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        carry_reg    <= carry_next;
        out_data_reg <= out_data_next;
    end

endmodule

// File: rtl/core/srt_cmp.sv
module srt_cmp
    import srt_pkg::*;
(
    input  logic signed [WORD_W-1:0] incoming,
    input  logic signed [WORD_W-1:0] carried,
    output logic signed [WORD_W-1:0] larger,
    output logic signed [WORD_W-1:0] smaller,
    output logic                     swap
);

    // signed compare, larger value moves to the front
    always_comb
    begin
        swap = (incoming > carried);
        if (swap)
        begin
            larger  = incoming;
            smaller = carried;
        end
        else
        begin
            larger  = carried;
            smaller = incoming;
        end
    end

endmodule
